@@ hw/rtl/swarq_pkg.sv @@
// Shared types, constants and helpers for the stop-and-wait ARQ receiver.
// Used by the front, queue, back and top level.
package swarq_pkg;

  // Payload ceiling and queue depth defaults
  localparam int MAX_PAYLOAD_DEF = 8192;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Word positions of the captured header fields
  localparam logic [3:0] POS_SEQ_LO = 4'd2;
  localparam logic [3:0] POS_SEQ_HI = 4'd3;
  localparam logic [3:0] POS_LEN    = 4'd6;
  localparam logic [3:0] POS_FLAG   = 4'd7;
  localparam logic [3:0] POS_SAT    = 4'd8;

  localparam logic [15:0] SUM_GOOD = 16'hffff;
  localparam logic [7:0]  FLAG_END = 8'h08;
  localparam logic [1:0]  ACK_END  = 2'd0;

  // Header summary of one finished packet
  typedef struct packed {
    logic [15:0] sum;
    logic [31:0] seq;
    logic [15:0] len;
    logic [7:0]  flag;
  } swarq_pkt_t;

  // Ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

@@ hw/rtl/swarq_ifs.sv @@
// Valid/ready channel interfaces: packet words in, acks out, config write.
// Depends on nothing but plain logic types.
interface swarq_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;
  logic        last;
  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

interface swarq_ack_if;
  logic        valid;
  logic        ready;
  logic        ack_sent;
  logic [1:0]  ack_number;
  logic        end_ack;
  logic        accepted;
  logic [13:0] payload_length;
  logic [31:0] total_length;
  modport source (output valid, output ack_sent, output ack_number, output end_ack,
                  output accepted, output payload_length, output total_length,
                  input ready);
  modport sink   (input valid, input ack_sent, input ack_number, input end_ack,
                  input accepted, input payload_length, input total_length,
                  output ready);
endinterface

interface swarq_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/swarq_front.sv @@
// Front end: folds packet words into the checksum and captures header fields.
// Depends on swarq_pkg; pushes one summary per packet into swarq_queue.
module swarq_front
  import swarq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       word_valid,
  input  logic [15:0] word,
  input  logic       last,
  output logic       word_ready,
  input  logic       queue_full,
  output logic       push,
  output swarq_pkt_t push_pkt
);

  logic [3:0]  pos;
  logic [15:0] sum;
  logic [31:0] seq;
  logic [15:0] len;
  logic [7:0]  flag;

  logic [3:0]  pos_next;
  logic [15:0] sum_next;
  logic [31:0] seq_next;
  logic [15:0] len_next;
  logic [7:0]  flag_next;
  logic        beat;

  assign word_ready = !queue_full;
  assign beat       = word_valid && word_ready;

  // Fold the word and capture fields at their positions
  always_comb begin
    sum_next  = oc_add(sum, word);
    seq_next  = seq;
    len_next  = len;
    flag_next = flag;
    case (pos)
      POS_SEQ_LO: seq_next  = {seq[31:16], word};
      POS_SEQ_HI: seq_next  = {word, seq[15:0]};
      POS_LEN:    len_next  = word;
      POS_FLAG:   flag_next = word[7:0];
      default:    ;
    endcase
    pos_next = (pos < POS_SAT) ? pos + 4'd1 : pos;
  end

  // Hand the finished header to the queue on the last beat
  assign push          = beat && last;
  assign push_pkt.sum  = sum_next;
  assign push_pkt.seq  = seq_next;
  assign push_pkt.len  = len_next;
  assign push_pkt.flag = flag_next;

  // Advance per-packet state; drop it after the last beat
  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos  <= '0;
      sum  <= '0;
      seq  <= '0;
      len  <= '0;
      flag <= '0;
    end else if (beat) begin
      pos  <= pos_next;
      sum  <= sum_next;
      seq  <= seq_next;
      len  <= len_next;
      flag <= flag_next;
    end
  end

endmodule

@@ hw/rtl/swarq_queue.sv @@
// Short FIFO of packet summaries between front and back.
// Depends on swarq_pkg for the summary type.
module swarq_queue
  import swarq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  swarq_pkt_t push_pkt,
  output logic       full,
  input  logic       pop,
  output logic       pkt_valid,
  output swarq_pkt_t pkt
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  swarq_pkt_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CNT_FULL);
  assign pkt_valid = (count != '0);
  assign pkt       = mem[rd_ptr];

  // Store pushed summaries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_pkt;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/swarq_back.sv @@
// Back end: checksum test, alternating-bit rule and ack output register.
// Depends on swarq_pkg; pops summaries from swarq_queue.
module swarq_back
  import swarq_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        pkt_valid,
  input  swarq_pkt_t  pkt,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ack_sent,
  output logic [1:0]  ack_number,
  output logic        end_ack,
  output logic        accepted,
  output logic [13:0] payload_length,
  output logic [31:0] total_length
);

  localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD);

  logic [15:0] pseudo_sum;
  logic        expect_odd;
  logic        transfer_started;
  logic [31:0] accepted_total;

  logic [13:0] plen;
  logic [31:0] total_grown;
  logic [1:0]  expected;
  logic [1:0]  previous;
  logic        good;
  logic        is_empty;
  logic        is_end;
  logic        is_bad_dup;
  logic        is_new;
  logic        produce;

  // Hold the pseudo-header sum
  always_ff @(posedge clk) begin
    if (rst) begin
      pseudo_sum <= '0;
    end else if (cfg_valid) begin
      pseudo_sum <= cfg_data;
    end
  end

  // Classify the packet at the head of the queue
  always_comb begin
    plen        = (pkt.len > LEN_MAX) ? LEN_MAX[13:0] : pkt.len[13:0];
    total_grown = accepted_total + {18'd0, plen};
    expected    = {1'b1, expect_odd};
    previous    = {1'b1, ~expect_odd};
    good        = (oc_add(pkt.sum, pseudo_sum) == SUM_GOOD);
    is_empty    = !expect_odd && (pkt.len == '0);
    is_end      = !is_empty && ((pkt.flag & FLAG_END) != '0) && transfer_started;
    is_bad_dup  = !is_empty && !is_end && (!good || pkt.seq == {30'd0, previous});
    is_new      = !is_empty && !is_end && !is_bad_dup && (pkt.seq == {30'd0, expected});
    produce     = is_end || is_bad_dup || is_new;
  end

  assign pop = pkt_valid && (!out_valid || out_ready);

  // Advance the receiver state per packet
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_odd       <= 1'b0;
      transfer_started <= 1'b0;
      accepted_total   <= '0;
    end else if (pop) begin
      if (is_end) begin
        expect_odd       <= 1'b0;
        transfer_started <= 1'b0;
        accepted_total   <= '0;
      end else if (is_new) begin
        expect_odd       <= ~expect_odd;
        transfer_started <= 1'b1;
        accepted_total   <= total_grown;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= produce;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      ack_sent       <= 1'b1;
      ack_number     <= is_end ? ACK_END : (is_new ? expected : previous);
      end_ack        <= is_end;
      accepted       <= is_new;
      payload_length <= plen;
      total_length   <= is_new ? total_grown : accepted_total;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_ack_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_ack |-> ack_number == ACK_END && !accepted)
    else $error("end ack with data number or accept");

  a_new_toggles: assert property (@(posedge clk) disable iff (rst)
    pop && is_new |=> expect_odd != $past(expect_odd) && transfer_started)
    else $error("new packet did not toggle expected sequence");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    pop && is_end |=> !expect_odd && !transfer_started && accepted_total == '0)
    else $error("end of transfer did not clear receiver state");
`endif

endmodule

@@ hw/rtl/stop_wait_arq_receiver.sv @@
// Top level of the stop-and-wait ARQ receiver front end.
// Depends on swarq_pkg, swarq_ifs, swarq_front, swarq_queue and swarq_back.
//
// Takes one 16-bit packet word per cycle on packet while the queue is not full;
// the word path folds each beat with a single ones-complement add, so packets
// may follow each other without gaps. The last word's header summary passes
// through a queue (two entries by default) to the decision stage, and the ack,
// if any, is registered in the ack output register once the summary leaves the
// queue. Packets that call for no ack (empty packets while expecting sequence 2,
// or unexpected sequence numbers with a good checksum) are dropped silently.
// The user writes pseudo_sum on cfg only while the block is idle; the block
// itself does not enforce this. cfg is always ready.
module stop_wait_arq_receiver
  import swarq_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  swarq_word_if.sink  packet,
  swarq_ack_if.source ack,
  swarq_cfg_if.sink   cfg
);

  logic       queue_full;
  logic       push;
  swarq_pkt_t push_pkt;
  logic       pop;
  logic       pkt_valid;
  swarq_pkt_t pkt;

  assign cfg.ready = 1'b1;

  // Accept and fold packet words
  swarq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .word_valid (packet.valid),
    .word       (packet.word),
    .last       (packet.last),
    .word_ready (packet.ready),
    .queue_full (queue_full),
    .push       (push),
    .push_pkt   (push_pkt)
  );

  // Buffer finished headers
  swarq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_pkt  (push_pkt),
    .full      (queue_full),
    .pop       (pop),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  // Decide and emit acks
  swarq_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg.valid),
    .cfg_data       (cfg.data),
    .pkt_valid      (pkt_valid),
    .pkt            (pkt),
    .pop            (pop),
    .out_valid      (ack.valid),
    .out_ready      (ack.ready),
    .ack_sent       (ack.ack_sent),
    .ack_number     (ack.ack_number),
    .end_ack        (ack.end_ack),
    .accepted       (ack.accepted),
    .payload_length (ack.payload_length),
    .total_length   (ack.total_length)
  );

endmodule

@@ tb/stop_wait_arq_receiver_checker.sv @@
`timescale 1ns / 100ps
// Ack checker for the stop-and-wait ARQ receiver: watches the word, cfg and ack channels.
// Predicts every ack from accepted word beats and compares it; needs swarq_pkg only.
module swarq_ack_checker
  import swarq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  input  logic        word_ready,
  input  logic [15:0] word,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        ack_valid,
  input  logic        ack_ready,
  input  logic        ack_sent,
  input  logic [1:0]  ack_number,
  input  logic        end_ack,
  input  logic        accepted,
  input  logic [13:0] payload_length,
  input  logic [31:0] total_length,
  output int          error_count,
  output int          outstanding
);

  localparam logic [12:0] POS_LIMIT  = 13'h1fff;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic        ack_sent;
    logic [1:0]  ack_number;
    logic        end_ack;
    logic        accepted;
    logic [13:0] payload_length;
    logic [31:0] total_length;
  } ack_beat_t;

  // Predicted acks, oldest first
  ack_beat_t pending_acks[$];

  // Shadow of the receiver state
  logic [15:0] pseudo_reg;
  logic [12:0] pos_count;
  logic [15:0] word_sum;
  logic [31:0] seq_capture;
  logic [15:0] len_capture;
  logic [7:0]  flag_capture;
  logic        odd_stage;
  logic        transfer_open;
  logic [31:0] committed_total;
  int          errors = 0;
  int          ack_index = 0;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_header();
    pos_count    = '0;
    word_sum     = '0;
    seq_capture  = '0;
    len_capture  = '0;
    flag_capture = '0;
  endtask

  // Fold one word beat into the packet; decide the ack on the last beat
  task automatic track_word(input logic [15:0] w, input logic fin);
    logic [13:0] plen;
    logic [1:0]  want_num;
    logic [1:0]  prior_num;
    logic        sum_ok;
    ack_beat_t   beat;
    word_sum = ones_add(word_sum, w);
    case (pos_count)
      13'(POS_SEQ_LO): seq_capture[15:0]  = w;
      13'(POS_SEQ_HI): seq_capture[31:16] = w;
      13'(POS_LEN):    len_capture        = w;
      13'(POS_FLAG):   flag_capture       = w[7:0];
      default: ;
    endcase
    if (pos_count != POS_LIMIT) pos_count = pos_count + 13'd1;
    if (!fin) return;

    // Saturate the length, test the checksum, pick the ack numbers
    plen      = (len_capture > 16'(MAX_PAYLOAD_DEF)) ? 14'(MAX_PAYLOAD_DEF) : len_capture[13:0];
    sum_ok    = (ones_add(word_sum, pseudo_reg) == SUM_GOOD);
    want_num  = odd_stage ? 2'd3 : 2'd2;
    prior_num = odd_stage ? 2'd2 : 2'd3;
    beat.ack_sent       = 1'b1;
    beat.ack_number     = ACK_END;
    beat.end_ack        = 1'b0;
    beat.accepted       = 1'b0;
    beat.payload_length = plen;
    beat.total_length   = committed_total;

    if (!odd_stage && len_capture == 16'd0) begin
      // Drop empty packet while expecting sequence 2
    end else if ((flag_capture & FLAG_END) != 8'd0 && transfer_open) begin
      beat.end_ack = 1'b1;
      pending_acks.push_back(beat);
      odd_stage       = 1'b0;
      transfer_open   = 1'b0;
      committed_total = '0;
    end else if (!sum_ok || seq_capture == {30'd0, prior_num}) begin
      beat.ack_number = prior_num;
      pending_acks.push_back(beat);
    end else if (seq_capture == {30'd0, want_num}) begin
      committed_total   = committed_total + 32'(plen);
      beat.ack_number   = want_num;
      beat.accepted     = 1'b1;
      beat.total_length = committed_total;
      pending_acks.push_back(beat);
      odd_stage     = ~odd_stage;
      transfer_open = 1'b1;
    end
    clear_header();
  endtask

  // Compare ack beats, then apply config and word beats of this edge
  always @(posedge clk) begin : watch
    ack_beat_t got;
    ack_beat_t want;
    if (rst) begin
      pending_acks.delete();
      pseudo_reg      = '0;
      odd_stage       = 1'b0;
      transfer_open   = 1'b0;
      committed_total = '0;
      clear_header();
    end else begin
      if (ack_valid && ack_ready) begin
        got = {ack_sent, ack_number, end_ack, accepted, payload_length, total_length};
        if (pending_acks.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $write("ack %0d: none expected,", ack_index);
            $display(" got sent=%0b num=%0d end=%0b acc=%0b len=%0d total=%0d",
                     got.ack_sent, got.ack_number, got.end_ack, got.accepted,
                     got.payload_length, got.total_length);
          end
        end else begin
          want = pending_acks.pop_front();
          if (want !== got) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $write("ack %0d: expected sent=%0b num=%0d end=%0b acc=%0b len=%0d total=%0d,",
                     ack_index, want.ack_sent, want.ack_number, want.end_ack, want.accepted,
                     want.payload_length, want.total_length);
              $display(" got sent=%0b num=%0d end=%0b acc=%0b len=%0d total=%0d",
                       got.ack_sent, got.ack_number, got.end_ack, got.accepted,
                       got.payload_length, got.total_length);
            end
          end
        end
        ack_index++;
      end
      if (cfg_valid && cfg_ready) pseudo_reg = cfg_data;
      if (word_valid && word_ready) track_word(word, last);
    end
    error_count <= errors;
    outstanding <= pending_acks.size();
  end

endmodule

@@ tb/stop_wait_arq_receiver_test.sv @@
`timescale 1ns / 100ps
// Top of the stop-and-wait ARQ receiver test: clock, reset, packet and ack traffic.
// Depends on swarq_pkg, swarq_ifs, the receiver RTL and swarq_ack_checker.
module stop_wait_arq_receiver_test
  import swarq_pkg::*;
;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int QUIET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_WORDS  = 100;
  localparam int LONG_PAYLOAD = 40;

  typedef enum int {
    PKT_WELL,
    PKT_BAD_SUM,
    PKT_STRAY_SEQ,
    PKT_END,
    PKT_SHORT,
    PKT_NOISE
  } pkt_kind_t;

  logic clk = 1'b0;
  logic rst;

  swarq_word_if packet_if ();
  swarq_ack_if  ack_if ();
  swarq_cfg_if  cfg_if ();

  int mismatch_total;
  int acks_outstanding;

  // Stimulus state, written by the main process; cycle_count by the hang watcher
  logic [15:0] pkt_words[$];
  logic [15:0] pseudo_now = '0;
  int          burst_left = 0;
  bit          steady     = 1'b0;
  int          words_sent = 0;
  int          hold_request = 0;
  int          cycle_count  = 0;

  stop_wait_arq_receiver i_dut (
    .clk    (clk),
    .rst    (rst),
    .packet (packet_if),
    .ack    (ack_if),
    .cfg    (cfg_if)
  );

  swarq_ack_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .word_valid     (packet_if.valid),
    .word_ready     (packet_if.ready),
    .word           (packet_if.word),
    .last           (packet_if.last),
    .cfg_valid      (cfg_if.valid),
    .cfg_ready      (cfg_if.ready),
    .cfg_data       (cfg_if.data),
    .ack_valid      (ack_if.valid),
    .ack_ready      (ack_if.ready),
    .ack_sent       (ack_if.ack_sent),
    .ack_number     (ack_if.ack_number),
    .end_ack        (ack_if.end_ack),
    .accepted       (ack_if.accepted),
    .payload_length (ack_if.payload_length),
    .total_length   (ack_if.total_length),
    .error_count    (mismatch_total),
    .outstanding    (acks_outstanding)
  );

  always #2 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Ack receiver: stall on a rotating pattern, hold off long on request
  initial begin : ack_side
    logic [7:0] stall_pattern;
    int         span;
    int         idx;
    int         holds_served;
    stall_pattern = 8'hff;
    span          = 0;
    idx           = 0;
    holds_served  = 0;
    ack_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != holds_served) begin
        ack_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end
      if (span == 0) begin
        span = $urandom_range(16, 128);
        case ($urandom_range(0, 3))
          0:       stall_pattern = 8'hff;
          1:       stall_pattern = 8'($urandom) | 8'h01;
          default: stall_pattern = 8'($urandom) | 8'h55;
        endcase
      end
      span--;
      ack_if.ready <= stall_pattern[idx];
      idx = (idx + 1) % 8;
    end
  end

  // Offer one word beat and hold it until accepted
  task automatic send_word(input logic [15:0] w, input logic fin);
    packet_if.valid <= 1'b1;
    packet_if.word  <= w;
    packet_if.last  <= fin;
    @(posedge clk);
    while (!packet_if.ready) @(posedge clk);
  endtask

  // Insert a random gap between bursts, none in steady mode
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        packet_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_packet_words();
    foreach (pkt_words[i]) begin
      pace_sender();
      send_word(pkt_words[i], i == pkt_words.size() - 1);
      words_sent++;
    end
  endtask

  // Drop valid and wait until every predicted ack has arrived
  task automatic settle();
    packet_if.valid <= 1'b0;
    do @(posedge clk); while (acks_outstanding != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_pseudo(input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    pseudo_now = v;
  endtask

  // Header plus payload, with the checksum word fixed up for the current pseudo sum unless corrupt is set
  task automatic build_packet(input logic [31:0] seq, input logic [15:0] len,
                              input logic [7:0] flag, input int payload_n, input bit corrupt);
    int unsigned acc;
    pkt_words.delete();
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(seq[15:0]);
    pkt_words.push_back(seq[31:16]);
    pkt_words.push_back(16'h0000);
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(len);
    pkt_words.push_back({8'($urandom), flag});
    repeat (payload_n) pkt_words.push_back(16'($urandom));
    acc = pseudo_now;
    foreach (pkt_words[i]) acc += pkt_words[i];
    while (acc > 32'hffff) acc = (acc & 32'hffff) + (acc >> 16);
    pkt_words[4] = ~acc[15:0];
    if (corrupt) pkt_words[4] = pkt_words[4] ^ 16'($urandom_range(1, 16'hffff));
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'($urandom_range(8193, 65535));
      2:       return ($urandom_range(0, 1) != 0) ? 16'd8192 : 16'hffff;
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  // Mostly well-formed packets, the rest damaged, stray, end of transfer, short or noise
  task automatic random_packet();
    pkt_kind_t   kind;
    int          pick;
    int          n;
    logic [31:0] seq;
    pick = $urandom_range(0, 99);
    if (pick < 55)      kind = PKT_WELL;
    else if (pick < 65) kind = PKT_BAD_SUM;
    else if (pick < 73) kind = PKT_STRAY_SEQ;
    else if (pick < 83) kind = PKT_END;
    else if (pick < 91) kind = PKT_SHORT;
    else                kind = PKT_NOISE;
    seq = 32'($urandom_range(2, 3));
    case (kind)
      PKT_WELL:
        build_packet(seq, pick_length(), 8'($urandom) & ~FLAG_END, $urandom_range(0, 4), 1'b0);
      PKT_BAD_SUM:
        build_packet(seq, pick_length(), 8'($urandom) & ~FLAG_END, $urandom_range(0, 4), 1'b1);
      PKT_STRAY_SEQ: begin
        seq = ($urandom_range(0, 1) != 0) ? 32'($urandom) : 32'($urandom_range(0, 5));
        build_packet(seq, pick_length(), 8'($urandom) & ~FLAG_END, $urandom_range(0, 4), 1'b0);
      end
      PKT_END:
        build_packet(seq, pick_length(), 8'($urandom) | FLAG_END, $urandom_range(0, 2),
                     $urandom_range(0, 3) == 0);
      PKT_SHORT: begin
        build_packet(seq, pick_length(), 8'($urandom), 0, 1'b0);
        n = $urandom_range(1, 7);
        pkt_words = pkt_words[0:n-1];
      end
      default: begin
        pkt_words.delete();
        n = $urandom_range(1, 12);
        repeat (n) pkt_words.push_back(16'($urandom));
      end
    endcase
    send_packet_words();
  endtask

  initial begin : stimulus
    logic [15:0] pseudo_plan [5];
    int          target;
    packet_if.valid <= 1'b0;
    packet_if.word  <= '0;
    packet_if.last  <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    rst             <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty packet, oversized new packet, duplicate, end of transfer
    write_pseudo(16'h0000);
    pkt_words = '{16'h0000};
    send_packet_words();
    build_packet(32'd2, 16'hffff, 8'h00, 0, 1'b0);
    send_packet_words();
    build_packet(32'd2, 16'd8192, 8'hf7, 0, 1'b0);
    send_packet_words();
    build_packet(32'd3, 16'h0001, FLAG_END, 0, 1'b0);
    send_packet_words();

    // Random phases, each under its own pseudo sum
    pseudo_plan = '{16'hffff, 16'($urandom), 16'h8000, 16'($urandom), 16'h0000};
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      write_pseudo(pseudo_plan[phase]);
      steady = (phase == 2);
      if (phase == 1) hold_request++;
      if (phase == 3) begin
        // Run past the saturated word position twice
        repeat (2) begin
          build_packet(32'($urandom_range(2, 3)), pick_length(), 8'($urandom) & ~FLAG_END,
                       LONG_PAYLOAD, 1'b0);
          send_packet_words();
        end
      end
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        random_packet();
        if ($urandom_range(0, 19) == 0) settle();
      end
    end

    settle();
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
